>>> hdl/cia_pkg.sv
// Package for the interval timer pair: word types, item kinds, register
// indexes and chip roles. Depends on nothing; used by cia_interval_timer_pair.
package cia_pkg;

  localparam int TIMER_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIMER_W-1:0] count_t;

  typedef enum logic [1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_LOAD_A  = 2'd1,
    KIND_LOAD_B  = 2'd2,
    KIND_ACK     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ROLE_IRQ  = 2'd0,
    ROLE_NMI  = 2'd1,
    ROLE_NONE = 2'd2,
    ROLE_OFF  = 2'd3
  } role_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHIP_ROLE = 3'd0,
    REG_A_LATCH   = 3'd1,
    REG_B_LATCH   = 3'd2,
    REG_A_CONTROL = 3'd3,
    REG_B_CONTROL = 3'd4
  } reg_idx_t;

  localparam int CTL_CONTINUOUS = 0;
  localparam int CTL_IRQ_EN     = 1;
  localparam int CTL_INMODE     = 2;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  cycles;
    logic        cpu_irq_masked;
    logic [15:0] load_value;
    logic        load_start;
  } in_word_t;

  typedef struct packed {
    logic        irq_raise;
    logic        nmi_raise;
    logic        a_flag;
    logic        b_flag;
    logic [15:0] a_count;
    logic [15:0] b_count;
    logic        a_running;
    logic        b_running;
  } out_word_t;

  typedef struct packed {
    count_t cnt;
    logic   run;
    logic   hit;
    logic   irq;
    logic   nmi;
  } tick_t;

endpackage

>>> hdl/cia_interval_timer_pair.sv
// Top level of the interval timer pair: state, update logic and result register.
// Depends on cia_pkg for word types, item kinds, register indexes and roles.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data (cia_pkg::in_word_t)
//   out     | output    | out_valid / out_ready| out_data (cia_pkg::out_word_t)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each word is processed in the cycle it is accepted; its result is in the output register
// in the cycle after. A new word is accepted every cycle while the output is empty or taken.
// The timer state is updated by one subtract and compare per timer at the accepting edge.
// A stalled output holds its result and blocks input only while it is full and not taken.
// Synchronous active-low reset clears timers, flags, config and output valid; result data is not reset.
module cia_interval_timer_pair (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cia_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cia_pkg::out_word_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cia_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cia_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cia_pkg::role_t  role_r;
  cia_pkg::count_t a_latch_r, b_latch_r;
  logic [2:0]      a_ctl_r, b_ctl_r;

  cia_pkg::count_t count_a_r, count_b_r, count_a_nxt, count_b_nxt;
  logic            run_a_r, run_b_r, run_a_nxt, run_b_nxt;
  logic            hit_a_r, hit_b_r, hit_a_nxt, hit_b_nxt;
  logic            irq_nxt, nmi_nxt;

  logic               out_valid_r;
  cia_pkg::out_word_t out_data_r;
  logic               in_fire;

  cia_pkg::tick_t tick_a, tick_b;

  function automatic cia_pkg::tick_t tick(
    input cia_pkg::count_t cnt,
    input logic            run,
    input logic            hit,
    input cia_pkg::count_t latch,
    input logic [2:0]      ctl,
    input logic [7:0]      cyc,
    input logic            masked,
    input cia_pkg::role_t  role
  );
    cia_pkg::tick_t  res;
    cia_pkg::count_t cyc_w;
    cyc_w = cia_pkg::count_t'(cyc);
    res.cnt = cnt;
    res.run = run;
    res.hit = hit;
    res.irq = 1'b0;
    res.nmi = 1'b0;
    if (cyc_w <= cnt) begin
      res.cnt = cnt - cyc_w;
    end else begin
      if (ctl[cia_pkg::CTL_CONTINUOUS]) begin
        res.cnt = latch;
      end else begin
        res.run = 1'b0;
      end
      if (ctl[cia_pkg::CTL_IRQ_EN]) begin
        if (role == cia_pkg::ROLE_IRQ && !masked) begin
          res.irq = 1'b1;
          res.hit = 1'b1;
        end else if (role == cia_pkg::ROLE_NMI) begin
          res.nmi = 1'b1;
          res.hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign tick_a = tick(count_a_r, run_a_r, hit_a_r, a_latch_r, a_ctl_r, in_data.cycles,
                       in_data.cpu_irq_masked, role_r);
  assign tick_b = tick(count_b_r, run_b_r, hit_b_r, b_latch_r, b_ctl_r, in_data.cycles,
                       in_data.cpu_irq_masked, role_r);

  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    run_a_nxt   = run_a_r;
    run_b_nxt   = run_b_r;
    hit_a_nxt   = hit_a_r;
    hit_b_nxt   = hit_b_r;
    irq_nxt     = 1'b0;
    nmi_nxt     = 1'b0;
    unique case (in_data.kind)
      cia_pkg::KIND_ADVANCE: begin
        if (run_a_r && !a_ctl_r[cia_pkg::CTL_INMODE]) begin
          count_a_nxt = tick_a.cnt;
          run_a_nxt   = tick_a.run;
          hit_a_nxt   = tick_a.hit;
          irq_nxt     = irq_nxt | tick_a.irq;
          nmi_nxt     = nmi_nxt | tick_a.nmi;
        end
        if (run_b_r && b_ctl_r[cia_pkg::CTL_INMODE]) begin
          count_b_nxt = tick_b.cnt;
          run_b_nxt   = tick_b.run;
          hit_b_nxt   = tick_b.hit;
          irq_nxt     = irq_nxt | tick_b.irq;
          nmi_nxt     = nmi_nxt | tick_b.nmi;
        end
      end
      cia_pkg::KIND_LOAD_A: begin
        count_a_nxt = cia_pkg::count_t'(in_data.load_value);
        run_a_nxt   = in_data.load_start;
      end
      cia_pkg::KIND_LOAD_B: begin
        count_b_nxt = cia_pkg::count_t'(in_data.load_value);
        run_b_nxt   = in_data.load_start;
      end
      cia_pkg::KIND_ACK: begin
        hit_a_nxt = 1'b0;
        hit_b_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r    <= cia_pkg::ROLE_IRQ;
      a_latch_r <= '0;
      b_latch_r <= '0;
      a_ctl_r   <= '0;
      b_ctl_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cia_pkg::REG_CHIP_ROLE: role_r    <= cia_pkg::role_t'(cfg_data[1:0]);
        cia_pkg::REG_A_LATCH:   a_latch_r <= cia_pkg::count_t'(cfg_data);
        cia_pkg::REG_B_LATCH:   b_latch_r <= cia_pkg::count_t'(cfg_data);
        cia_pkg::REG_A_CONTROL: a_ctl_r   <= cfg_data[2:0];
        cia_pkg::REG_B_CONTROL: b_ctl_r   <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      run_a_r     <= 1'b0;
      run_b_r     <= 1'b0;
      hit_a_r     <= 1'b0;
      hit_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_a_r   <= count_a_nxt;
        count_b_r   <= count_b_nxt;
        run_a_r     <= run_a_nxt;
        run_b_r     <= run_b_nxt;
        hit_a_r     <= hit_a_nxt;
        hit_b_r     <= hit_b_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.irq_raise <= irq_nxt;
      out_data_r.nmi_raise <= nmi_nxt;
      out_data_r.a_flag    <= hit_a_nxt;
      out_data_r.b_flag    <= hit_b_nxt;
      out_data_r.a_count   <= 16'(count_a_nxt);
      out_data_r.b_count   <= 16'(count_b_nxt);
      out_data_r.a_running <= run_a_nxt;
      out_data_r.b_running <= run_b_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_line_raised: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.irq_raise && out_data_r.nmi_raise))
    else $error("IRQ and NMI raised by the same word");

  a_irq_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.irq_raise || out_data_r.nmi_raise))
      |-> (out_data_r.a_flag || out_data_r.b_flag))
    else $error("Interrupt raised without a timer flag set");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.kind == cia_pkg::KIND_ACK)
      |=> (!hit_a_r && !hit_b_r && !out_data_r.a_flag && !out_data_r.b_flag))
    else $error("Acknowledge did not clear the flags");

  a_load_a_value: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.kind == cia_pkg::KIND_LOAD_A)
      |=> (out_data_r.a_count == $past(in_data.load_value)))
    else $error("Timer A load value not reported");

  a_run_a_only_by_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(run_a_r) |-> $past(in_fire && in_data.kind == cia_pkg::KIND_LOAD_A))
    else $error("Timer A started without a load");
`endif

endmodule

>>> tb/tb_cia_interval_timer_pair.sv
// Self-checking testbench for cia_interval_timer_pair: a burst driver, a stalling monitor and an
// in-line timer predictor that checks every result word field by field.
// Depends on cia_pkg for word types, item kinds, register indexes and chip roles.
module tb_cia_interval_timer_pair;

  localparam int PHASE_WORDS = 50;
  localparam int RANDOM_PHASES = 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  cia_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cia_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cia_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cia_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  cia_pkg::in_word_t pending_words[$];
  cia_pkg::out_word_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;

  cia_pkg::role_t model_role = cia_pkg::ROLE_IRQ;
  cia_pkg::count_t model_a_latch = '0;
  cia_pkg::count_t model_b_latch = '0;
  logic [2:0] model_a_ctl = '0;
  logic [2:0] model_b_ctl = '0;
  cia_pkg::count_t model_a_count = '0;
  cia_pkg::count_t model_b_count = '0;
  logic model_a_run = 1'b0;
  logic model_b_run = 1'b0;
  logic model_a_hit = 1'b0;
  logic model_b_hit = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_phase = 0;

  cia_interval_timer_pair dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void count_down(inout cia_pkg::count_t cnt, inout logic run,
                                     inout logic hit, input cia_pkg::count_t latch,
                                     input logic [2:0] ctl,
                                     input logic [7:0] cyc, input logic masked,
                                     inout logic irq, inout logic nmi);
    if (cia_pkg::count_t'(cyc) <= cnt) begin
      cnt = cnt - cia_pkg::count_t'(cyc);
      return;
    end
    if (ctl[cia_pkg::CTL_CONTINUOUS]) cnt = latch;
    else run = 1'b0;
    if (ctl[cia_pkg::CTL_IRQ_EN]) begin
      if (model_role == cia_pkg::ROLE_IRQ && !masked) begin
        irq = 1'b1;
        hit = 1'b1;
      end else if (model_role == cia_pkg::ROLE_NMI) begin
        nmi = 1'b1;
        hit = 1'b1;
      end
    end
  endfunction

  function automatic cia_pkg::out_word_t predict_timer_word(cia_pkg::in_word_t w);
    cia_pkg::out_word_t r;
    logic irq;
    logic nmi;
    irq = 1'b0;
    nmi = 1'b0;
    case (w.kind)
      cia_pkg::KIND_ADVANCE: begin
        if (model_a_run && !model_a_ctl[cia_pkg::CTL_INMODE])
          count_down(model_a_count, model_a_run, model_a_hit, model_a_latch, model_a_ctl,
                     w.cycles, w.cpu_irq_masked, irq, nmi);
        if (model_b_run && model_b_ctl[cia_pkg::CTL_INMODE])
          count_down(model_b_count, model_b_run, model_b_hit, model_b_latch, model_b_ctl,
                     w.cycles, w.cpu_irq_masked, irq, nmi);
      end
      cia_pkg::KIND_LOAD_A: begin
        model_a_count = w.load_value;
        model_a_run = w.load_start;
      end
      cia_pkg::KIND_LOAD_B: begin
        model_b_count = w.load_value;
        model_b_run = w.load_start;
      end
      default: begin
        model_a_hit = 1'b0;
        model_b_hit = 1'b0;
      end
    endcase
    r.irq_raise = irq;
    r.nmi_raise = nmi;
    r.a_flag = model_a_hit;
    r.b_flag = model_b_hit;
    r.a_count = model_a_count;
    r.b_count = model_b_count;
    r.a_running = model_a_run;
    r.b_running = model_b_run;
    return r;
  endfunction

  function automatic cia_pkg::in_word_t make_word(cia_pkg::kind_t kind, logic [7:0] cyc,
                                                  logic masked, logic [15:0] value,
                                                  logic start);
    cia_pkg::in_word_t w;
    w.kind = kind;
    w.cycles = cyc;
    w.cpu_irq_masked = masked;
    w.load_value = value;
    w.load_start = start;
    return w;
  endfunction

  function automatic cia_pkg::in_word_t random_timer_word();
    cia_pkg::in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.cycles = 8'($urandom_range(0, 255));
    w.cpu_irq_masked = ($urandom_range(0, 2) == 0);
    w.load_value = 16'($urandom_range(0, 65535));
    w.load_start = 1'($urandom_range(0, 1));
    if (pick < 55) w.kind = cia_pkg::KIND_ADVANCE;
    else if (pick < 72) w.kind = cia_pkg::KIND_LOAD_A;
    else if (pick < 89) w.kind = cia_pkg::KIND_LOAD_B;
    else w.kind = cia_pkg::KIND_ACK;
    if ((w.kind == cia_pkg::KIND_LOAD_A || w.kind == cia_pkg::KIND_LOAD_B) &&
        $urandom_range(0, 7) != 0) begin
      w.load_value = 16'($urandom_range(0, 700));
      w.load_start = ($urandom_range(0, 7) != 0);
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                words_seen, name, got, want));
  endtask

  task automatic write_reg(cia_pkg::reg_idx_t idx, logic [cia_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cia_pkg::REG_CHIP_ROLE: model_role = cia_pkg::role_t'(value[1:0]);
      cia_pkg::REG_A_LATCH:   model_a_latch = value;
      cia_pkg::REG_B_LATCH:   model_b_latch = value;
      cia_pkg::REG_A_CONTROL: model_a_ctl = value[2:0];
      cia_pkg::REG_B_CONTROL: model_b_ctl = value[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(predict_timer_word(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left != 0 || pending_words.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
      end else begin
        cia_pkg::out_word_t want;
        want = expected_words.pop_front();
        compare_field("irq_raise", 16'(out_data.irq_raise), 16'(want.irq_raise));
        compare_field("nmi_raise", 16'(out_data.nmi_raise), 16'(want.nmi_raise));
        compare_field("a_flag", 16'(out_data.a_flag), 16'(want.a_flag));
        compare_field("b_flag", 16'(out_data.b_flag), 16'(want.b_flag));
        compare_field("a_count", out_data.a_count, want.a_count);
        compare_field("b_count", out_data.b_count, want.b_count);
        compare_field("a_running", 16'(out_data.a_running), 16'(want.a_running));
        compare_field("b_running", 16'(out_data.b_running), 16'(want.b_running));
      end
    end
    ready_phase++;
    if (ready_phase[5:0] == 6'd0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom) & 16'($urandom);
        default: ready_pattern = 16'hF0F3;
      endcase
    end
    out_ready <= ready_pattern[ready_phase[3:0]];
  end

  initial begin
    #2_000_000;
    $display("cia_interval_timer_pair test failed");
    $finish;
  end

  initial begin
    logic [2:0] ctl;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Timer A continuous with interrupts, timer B one-shot with interrupts and counting.
    write_reg(cia_pkg::REG_CHIP_ROLE, 16'(cia_pkg::ROLE_IRQ));
    write_reg(cia_pkg::REG_A_LATCH, 16'd5);
    write_reg(cia_pkg::REG_B_LATCH, 16'hFFFF);
    write_reg(cia_pkg::REG_A_CONTROL, 16'd3);
    write_reg(cia_pkg::REG_B_CONTROL, 16'd6);
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_A, 8'd0, 1'b0, 16'd10, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_B, 8'd0, 1'b0, 16'd3, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd10, 1'b0, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_ACK, 8'd0, 1'b0, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd1, 1'b1, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd0, 1'b0, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd255, 1'b0, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_A, 8'd0, 1'b0, 16'hFFFF, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd255, 1'b0, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_B, 8'd0, 1'b0, 16'hFFFF, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd255, 1'b1, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_A, 8'd0, 1'b0, 16'd0, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ACK, 8'hFF, 1'b1, 16'hFFFF, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_B, 8'hFF, 1'b1, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd0, 1'b0, 16'hFFFF, 1'b1));
    wait_idle();

    write_reg(cia_pkg::REG_CHIP_ROLE, 16'(cia_pkg::ROLE_NMI));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_A, 8'd0, 1'b0, 16'd2, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd3, 1'b1, 16'd0, 1'b0));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_B, 8'd0, 1'b0, 16'd1, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd2, 1'b0, 16'd0, 1'b0));
    wait_idle();

    write_reg(cia_pkg::REG_CHIP_ROLE, 16'(cia_pkg::ROLE_NONE));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_A, 8'd0, 1'b0, 16'd0, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd1, 1'b0, 16'd0, 1'b0));
    wait_idle();

    // Both timers held by their input-mode bits.
    write_reg(cia_pkg::REG_CHIP_ROLE, 16'(cia_pkg::ROLE_OFF));
    write_reg(cia_pkg::REG_A_CONTROL, 16'd4);
    write_reg(cia_pkg::REG_B_CONTROL, 16'd0);
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_A, 8'd0, 1'b0, 16'd3, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_LOAD_B, 8'd0, 1'b0, 16'd3, 1'b1));
    pending_words.push_back(make_word(cia_pkg::KIND_ADVANCE, 8'd100, 1'b0, 16'd0, 1'b0));
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(cia_pkg::REG_CHIP_ROLE, 16'(cia_pkg::ROLE_OFF));
          write_reg(cia_pkg::REG_A_LATCH, 16'd0);
          write_reg(cia_pkg::REG_B_LATCH, 16'hFFFF);
          write_reg(cia_pkg::REG_A_CONTROL, 16'd0);
          write_reg(cia_pkg::REG_B_CONTROL, 16'd7);
        end
        1: begin
          write_reg(cia_pkg::REG_CHIP_ROLE, 16'(cia_pkg::ROLE_IRQ));
          write_reg(cia_pkg::REG_A_LATCH, 16'hFFFF);
          write_reg(cia_pkg::REG_B_LATCH, 16'd0);
          write_reg(cia_pkg::REG_A_CONTROL, 16'd3);
          write_reg(cia_pkg::REG_B_CONTROL, 16'd7);
        end
        default: begin
          write_reg(cia_pkg::REG_CHIP_ROLE, {14'($urandom), 2'($urandom_range(0, 3))});
          write_reg(cia_pkg::REG_A_LATCH, ($urandom_range(0, 3) == 0) ?
                    16'($urandom) : 16'($urandom_range(0, 400)));
          write_reg(cia_pkg::REG_B_LATCH, ($urandom_range(0, 3) == 0) ?
                    16'($urandom) : 16'($urandom_range(0, 400)));
          ctl = 3'($urandom_range(0, 7));
          if ($urandom_range(0, 4) != 0) ctl[cia_pkg::CTL_INMODE] = 1'b0;
          write_reg(cia_pkg::REG_A_CONTROL, {13'($urandom), ctl});
          ctl = 3'($urandom_range(0, 7));
          if ($urandom_range(0, 4) != 0) ctl[cia_pkg::CTL_INMODE] = 1'b1;
          write_reg(cia_pkg::REG_B_CONTROL, {13'($urandom), ctl});
        end
      endcase
      @(negedge clk);
      repeat (PHASE_WORDS) pending_words.push_back(random_timer_word());
      wait_idle();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) $display("cia_interval_timer_pair test passed");
    else $display("cia_interval_timer_pair test failed");
    $finish;
  end

endmodule
